>>> hdl/prq_pkg.sv
package prq_pkg;

	localparam int NUM_TASKS = 64;
	localparam int PRIO_MAX  = 15;
	localparam int LEVELS    = PRIO_MAX + 1;
	localparam int ID_W      = $clog2(NUM_TASKS);
	localparam int LINK_W    = $clog2(NUM_TASKS + 1);
	localparam int PRIO_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int TIME_W    = 64;
	localparam int WOKEN_W   = 7;

	localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_TASKS);

	// command codes
	localparam logic [2:0] CMD_ENQ   = 3'd0;
	localparam logic [2:0] CMD_SLEEP = 3'd1;
	localparam logic [2:0] CMD_BLOCK = 3'd2;
	localparam logic [2:0] CMD_TICK  = 3'd3;
	localparam logic [2:0] CMD_PICK  = 3'd4;

	// result status codes
	localparam logic [1:0] RS_DONE    = 2'd0;
	localparam logic [1:0] RS_REFUSED = 2'd1;
	localparam logic [1:0] RS_EMPTY   = 2'd2;

	// task states
	localparam logic [2:0] TS_READY    = 3'd0;
	localparam logic [2:0] TS_SLEEPING = 3'd1;
	localparam logic [2:0] TS_BLOCKED  = 3'd2;
	localparam logic [2:0] TS_RUNNING  = 3'd3;
	localparam logic [2:0] TS_NEW      = 3'd4;

	// list membership
	localparam logic [1:0] MB_NONE  = 2'd0;
	localparam logic [1:0] MB_RUN   = 2'd1;
	localparam logic [1:0] MB_SLEEP = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0] deadline;
		logic [1:0]        member;
		logic [2:0]        st;
		logic [PRIO_W-1:0] prio;
		logic [LINK_W-1:0] link;
	} word_t;

	localparam int WORD_W = $bits(word_t);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TASK,
		S_PICK,
		S_TICK,
		S_FIX
	} fsm_t;

	// signed request clamped to 0..PRIO_MAX
	function automatic logic [PRIO_W-1:0] clamp_prio(input logic [7:0] raw);
		logic [PRIO_W-1:0] r;
		if (raw[7]) begin
			r = '0;
		end else if (32'(raw) > PRIO_MAX) begin
			r = PRIO_W'(PRIO_MAX);
		end else begin
			r = PRIO_W'(raw);
		end
		return r;
	endfunction

endpackage

>>> hdl/prq_ram.sv
module prq_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/priority_run_queue_with_sleep_timers_top.sv
// Enqueue, sleep, block and a non-empty pick read one task entry and answer from it; an empty pick,
// an empty tick and an unknown command answer straight from idle; a tick walks the sleep list,
// visiting each sleeper, with an extra fix-up step for each woken sleeper with a kept one before it.
// One command at a time; the next beat is taken in the cycle done is high, and a table command
// is a read-modify-write of one task entry.
// Reset (arst_n low) empties all lists and marks every task new at once via
// per-entry valid bits; no clearing pass. Results cannot be stalled.
module priority_run_queue_with_sleep_timers_top
	import prq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        command,
	input  logic [5:0]        task_id,
	input  logic [7:0]        priority_req,
	input  logic [63:0]       now_time,
	input  logic [63:0]       duration,
	output logic              done,
	output logic [1:0]        status,
	output logic [5:0]        result_task,
	output logic [2:0]        task_state,
	output logic [6:0]        woken_count
);

	fsm_t state_q, state_d;

	logic [2:0]         cmd_q;
	logic [ID_W-1:0]    cur_q;
	logic [PRIO_W-1:0]  prio_q;
	logic [PRIO_W-1:0]  lvl_q;
	logic [TIME_W-1:0]  now_q;
	logic [TIME_W-1:0]  dl_q;
	logic [LINK_W-1:0]  nxt_q;
	logic [WOKEN_W-1:0] woken_q;
	logic               prev_vld_q;
	logic [ID_W-1:0]    prev_id_q;
	word_t              prev_q;

	logic [LINK_W-1:0]  level_head_q [LEVELS];
	logic [LINK_W-1:0]  sleep_head_q;
	logic [NUM_TASKS-1:0] valid_q;
	logic               rd_vld_q;

	// RAM port
	logic              we;
	logic [ID_W-1:0]   waddr;
	word_t             wdata;
	logic [ID_W-1:0]   raddr;
	logic [WORD_W-1:0] rdata;
	word_t             eff;

	logic accept;
	logic id_ok;
	logic any_rdy;
	logic [PRIO_W-1:0] top_lvl;
	logic wake;
	logic [LINK_W-1:0] adv_id;
	logic adv_end;
	logic [WOKEN_W-1:0] woken_inc;

	// finish beat
	logic               fin;
	logic [1:0]         fin_status;
	logic [5:0]         fin_task;
	logic [2:0]         fin_state;
	logic [WOKEN_W-1:0] fin_woken;

	// head updates
	logic               lh_we;
	logic [PRIO_W-1:0]  lh_idx;
	logic [LINK_W-1:0]  lh_val;
	logic               sh_we;
	logic [LINK_W-1:0]  sh_val;

	prq_ram #(.DEPTH(NUM_TASKS), .WIDTH(WORD_W)) u_tbl (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign id_ok  = (32'(task_id) < NUM_TASKS);

	// never-written entries read as a fresh task
	always_comb begin
		eff = word_t'(rdata);
		if (!rd_vld_q) begin
			eff.member = MB_NONE;
			eff.st     = TS_NEW;
			eff.link   = NIL;
			eff.prio   = '0;
		end
	end

	// highest non-empty level
	always_comb begin
		any_rdy = 1'b0;
		top_lvl = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (level_head_q[i] != NIL) begin
				any_rdy = 1'b1;
				top_lvl = PRIO_W'(i);
			end
		end
	end

	assign wake      = (eff.deadline <= now_q);
	assign adv_id    = (state_q == S_FIX) ? nxt_q : eff.link;
	assign adv_end   = (adv_id == NIL);
	assign woken_inc = (woken_q == '1) ? woken_q : woken_q + 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (command)
						CMD_ENQ, CMD_SLEEP, CMD_BLOCK: begin
							if (id_ok) state_d = S_TASK;
						end
						CMD_TICK: begin
							if (sleep_head_q != NIL) state_d = S_TICK;
						end
						CMD_PICK: begin
							if (any_rdy) state_d = S_PICK;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_TASK, S_PICK: state_d = S_IDLE;
			S_TICK: begin
				if (wake && prev_vld_q) begin
					state_d = S_FIX;
				end else if (adv_end) begin
					state_d = S_IDLE;
				end
			end
			S_FIX: state_d = adv_end ? S_IDLE : S_TICK;
			default: state_d = S_IDLE;
		endcase
	end

	// datapath controls and result
	always_comb begin
		we = 1'b0;
		waddr = cur_q;
		wdata = eff;
		raddr = cur_q;
		lh_we = 1'b0;
		lh_idx = '0;
		lh_val = NIL;
		sh_we = 1'b0;
		sh_val = NIL;
		fin = 1'b0;
		fin_status = RS_DONE;
		fin_task = '0;
		fin_state = '0;
		fin_woken = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (command)
						CMD_ENQ, CMD_SLEEP, CMD_BLOCK: begin
							raddr = task_id[ID_W-1:0];
							if (!id_ok) begin
								fin = 1'b1;
								fin_task = task_id;
								fin_state = TS_NEW;
							end
						end
						CMD_TICK: begin
							raddr = sleep_head_q[ID_W-1:0];
							fin = (sleep_head_q == NIL);
						end
						CMD_PICK: begin
							raddr = level_head_q[top_lvl][ID_W-1:0];
							if (!any_rdy) begin
								fin = 1'b1;
								fin_status = RS_EMPTY;
							end
						end
						default: fin = 1'b1;
					endcase
				end
			end
			S_TASK: begin
				fin = 1'b1;
				fin_task = 6'(cur_q);
				fin_state = eff.st;
				if (cmd_q == CMD_BLOCK) begin
					we = 1'b1;
					wdata.st = TS_BLOCKED;
					fin_state = TS_BLOCKED;
				end else if (eff.member != MB_NONE) begin
					fin_status = RS_REFUSED;
				end else if (cmd_q == CMD_ENQ) begin
					we = 1'b1;
					wdata.prio = prio_q;
					wdata.st = TS_READY;
					wdata.member = MB_RUN;
					wdata.link = level_head_q[prio_q];
					lh_we = 1'b1;
					lh_idx = prio_q;
					lh_val = LINK_W'(cur_q);
					fin_state = TS_READY;
				end else begin
					we = 1'b1;
					wdata.prio = prio_q;
					wdata.st = TS_SLEEPING;
					wdata.member = MB_SLEEP;
					wdata.deadline = dl_q;
					wdata.link = sleep_head_q;
					sh_we = 1'b1;
					sh_val = LINK_W'(cur_q);
					fin_state = TS_SLEEPING;
				end
			end
			S_PICK: begin
				we = 1'b1;
				wdata.link = NIL;
				wdata.st = TS_RUNNING;
				wdata.member = MB_NONE;
				lh_we = 1'b1;
				lh_idx = lvl_q;
				lh_val = eff.link;
				fin = 1'b1;
				fin_task = 6'(cur_q);
				fin_state = TS_RUNNING;
			end
			S_TICK, S_FIX: begin
				raddr = adv_id[ID_W-1:0];
				if (state_q == S_FIX) begin
					we = 1'b1;
					waddr = prev_id_q;
					wdata = prev_q;
					wdata.link = nxt_q;
				end else if (wake) begin
					// move this sleeper to the head of its level
					we = 1'b1;
					wdata.st = TS_READY;
					wdata.member = MB_RUN;
					wdata.link = level_head_q[eff.prio];
					lh_we = 1'b1;
					lh_idx = eff.prio;
					lh_val = LINK_W'(cur_q);
					if (!prev_vld_q) begin
						sh_we = 1'b1;
						sh_val = eff.link;
					end
				end
				if (state_d == S_IDLE) begin
					fin = 1'b1;
					fin_woken = (state_q == S_TICK && wake) ? woken_inc : woken_q;
				end
			end
			default: fin = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sleep_head_q <= NIL;
			valid_q <= '0;
			done <= 1'b0;
			for (int i = 0; i < LEVELS; i++) begin
				level_head_q[i] <= NIL;
			end
		end else begin
			state_q <= state_d;
			done <= fin;
			if (lh_we) level_head_q[lh_idx] <= lh_val;
			if (sh_we) sleep_head_q <= sh_val;
			if (we) valid_q[waddr] <= 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_vld_q <= valid_q[raddr];
		if (fin) begin
			status <= fin_status;
			result_task <= fin_task;
			task_state <= fin_state;
			woken_count <= fin_woken;
		end
		if (accept) begin
			cmd_q <= command;
			prio_q <= clamp_prio(priority_req);
			now_q <= now_time;
			dl_q <= now_time + duration;
			lvl_q <= top_lvl;
			woken_q <= '0;
			prev_vld_q <= 1'b0;
			case (command)
				CMD_TICK: cur_q <= sleep_head_q[ID_W-1:0];
				CMD_PICK: cur_q <= level_head_q[top_lvl][ID_W-1:0];
				default:  cur_q <= task_id[ID_W-1:0];
			endcase
		end else if (state_q == S_TICK) begin
			if (wake) begin
				woken_q <= woken_inc;
			end else begin
				prev_vld_q <= 1'b1;
				prev_id_q <= cur_q;
				prev_q <= eff;
			end
			nxt_q <= eff.link;
			if (!(wake && prev_vld_q)) cur_q <= adv_id[ID_W-1:0];
		end else if (state_q == S_FIX) begin
			prev_q.link <= nxt_q;
			cur_q <= adv_id[ID_W-1:0];
		end
	end

endmodule

>>> hdl/prq_checker.sv
module prq_checker
	import prq_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] status,
	input logic [5:0] result_task,
	input logic [2:0] task_state,
	input logic [6:0] woken_count
);

	// every accepted beat either goes busy or answers at once
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted beat neither started work nor answered");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status == RS_DONE || status == RS_REFUSED || status == RS_EMPTY)
		else $error("bad status code");

	a_empty_pick: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == RS_EMPTY |-> result_task == '0 && task_state == '0)
		else $error("empty pick carries a task");

	// a refused task is still on a list, so it cannot be running or new
	a_refused_state: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == RS_REFUSED |->
			task_state == TS_READY || task_state == TS_SLEEPING ||
			task_state == TS_BLOCKED)
		else $error("refused task in impossible state");

	a_tick_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && woken_count != '0 |-> status == RS_DONE && result_task == '0 &&
			task_state == '0)
		else $error("tick result carries task fields");

endmodule

bind priority_run_queue_with_sleep_timers_top prq_checker u_prq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.result_task (result_task),
	.task_state  (task_state),
	.woken_count (woken_count)
);
